### sv/spp_pkg.sv
package spp_pkg;

  localparam int CFG_W  = 18;
  localparam int IDX_W  = 3;
  localparam int DLY_W  = 18;
  localparam int GAIN_W = 16;
  localparam int QF     = 15;

  localparam logic [GAIN_W:0] UNITY    = 17'd32768;
  localparam int              RND_HALF = 16384;

  typedef enum logic [IDX_W-1:0] {
    REG_DELAY_LEN = 3'd0,
    REG_FEEDBACK  = 3'd1,
    REG_MIX       = 3'd2,
    REG_PING_PONG = 3'd3
  } reg_idx_e;

  // one item entering the datapath
  typedef struct packed {
    logic v;
    logic byp;
    logic ok;
  } issue_t;

  // datapath occupancy seen by the issue logic
  typedef struct packed {
    logic s1_v;
    logic s1_byp;
    logic s2_v;
    logic s2_byp;
    logic s1_free;
  } stat_t;

endpackage

### sv/spp_in_if.sv
interface spp_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

### sv/spp_out_if.sv
interface spp_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

### sv/spp_ram.sv
module spp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 262144
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/spp_dp.sv
module spp_dp #(
  parameter int SB = 24,
  parameter int AW = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spp_pkg::issue_t             issue_i,
  input  logic [AW-1:0]               wp_i,
  input  logic signed [SB-1:0]        left_i,
  input  logic signed [SB-1:0]        right_i,
  input  logic [2*SB-1:0]             rdata_i,
  input  logic [spp_pkg::GAIN_W:0]    fb_i,
  input  logic [spp_pkg::GAIN_W:0]    mix_i,
  input  logic                        pp_i,
  input  logic                        out_ready_i,
  output spp_pkg::stat_t              stat_o,
  output logic [AW-1:0]               s1_wp_o,
  output logic [AW-1:0]               s2_wp_o,
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [2*SB-1:0]             wdata_o,
  output logic                        out_valid_o,
  output logic signed [SB-1:0]        left_o,
  output logic signed [SB-1:0]        right_o
);
  import spp_pkg::*;

  localparam int PW = SB + GAIN_W + 2;
  localparam int SW = PW - QF;
  localparam logic signed [SW-1:0] HI = SW'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > HI) r = HI[SB-1:0];
    else if (v < LO) r = LO[SB-1:0];
    else r = v[SB-1:0];
    return r;
  endfunction

  function automatic logic signed [SW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + PW'(RND_HALF);
    return $signed(t[PW-1:QF]);
  endfunction

  // stage 1: ram data arrives
  logic                 s1_v_q, s1_byp_q, s1_ok_q;
  logic [AW-1:0]        s1_wp_q;
  logic signed [SB-1:0] s1_l_q, s1_r_q;
  // stage 2: products
  logic                 s2_v_q, s2_byp_q;
  logic [AW-1:0]        s2_wp_q;
  logic signed [SB-1:0] s2_l_q, s2_r_q;
  logic signed [PW-1:0] s2_fl_q, s2_fr_q, s2_ml_q, s2_mr_q;
  // output register
  logic                 out_v_q;
  logic signed [SB-1:0] out_l_q, out_r_q;

  logic                 out_load, s2_free, s1_free;
  logic signed [SB-1:0] dl, dr, fsel_l, fsel_r;
  logic signed [SB:0]   diff_l, diff_r;
  logic signed [PW-1:0] fb_s, mix_s;
  logic signed [PW-1:0] fl_d, fr_d, ml_d, mr_d;
  logic signed [SB-1:0] wl, wr, ol, orr;

  assign out_load = !out_v_q || out_ready_i;
  assign s2_free  = !s2_v_q || out_load;
  assign s1_free  = !s1_v_q || s2_free;

  // entries never written read as zero
  assign dl = s1_ok_q ? $signed(rdata_i[SB-1:0])    : '0;
  assign dr = s1_ok_q ? $signed(rdata_i[2*SB-1:SB]) : '0;
  assign fsel_l = pp_i ? dr : dl;
  assign fsel_r = pp_i ? dl : dr;
  assign diff_l = (SB+1)'(dl) - (SB+1)'(s1_l_q);
  assign diff_r = (SB+1)'(dr) - (SB+1)'(s1_r_q);
  assign fb_s   = PW'($signed({1'b0, fb_i}));
  assign mix_s  = PW'($signed({1'b0, mix_i}));
  assign fl_d   = PW'(fsel_l) * fb_s;
  assign fr_d   = PW'(fsel_r) * fb_s;
  assign ml_d   = PW'(diff_l) * mix_s;
  assign mr_d   = PW'(diff_r) * mix_s;

  assign wl  = sat(SW'(s2_l_q) + rnd(s2_fl_q));
  assign wr  = sat(SW'(s2_r_q) + rnd(s2_fr_q));
  assign ol  = s2_byp_q ? s2_l_q : sat(SW'(s2_l_q) + rnd(s2_ml_q));
  assign orr = s2_byp_q ? s2_r_q : sat(SW'(s2_r_q) + rnd(s2_mr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= issue_i.v;
      if (s2_free) s2_v_q <= s1_v_q;
      if (out_load) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && issue_i.v) begin
      s1_byp_q <= issue_i.byp;
      s1_ok_q  <= issue_i.ok;
      s1_wp_q  <= wp_i;
      s1_l_q   <= left_i;
      s1_r_q   <= right_i;
    end
    if (s2_free && s1_v_q) begin
      s2_byp_q <= s1_byp_q;
      s2_wp_q  <= s1_wp_q;
      s2_l_q   <= s1_l_q;
      s2_r_q   <= s1_r_q;
      s2_fl_q  <= fl_d;
      s2_fr_q  <= fr_d;
      s2_ml_q  <= ml_d;
      s2_mr_q  <= mr_d;
    end
    if (out_load && s2_v_q) begin
      out_l_q <= ol;
      out_r_q <= orr;
    end
  end

  assign we_o    = s2_v_q && out_load && !s2_byp_q;
  assign waddr_o = s2_wp_q;
  assign wdata_o = {wr, wl};

  assign s1_wp_o = s1_wp_q;
  assign s2_wp_o = s2_wp_q;

  assign stat_o.s1_v    = s1_v_q;
  assign stat_o.s1_byp  = s1_byp_q;
  assign stat_o.s2_v    = s2_v_q;
  assign stat_o.s2_byp  = s2_byp_q;
  assign stat_o.s1_free = s1_free;

  assign out_valid_o = out_v_q;
  assign left_o      = out_l_q;
  assign right_o     = out_r_q;

`ifndef SYNTHESIS
  a_write_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |=> out_v_q)
    else $error("ram write without a result");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_l_q) && $stable(out_r_q)))
    else $error("result changed while stalled");
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_free && !issue_i.v) |=> (s2_v_q && !s1_v_q))
    else $error("stage 1 item lost");
`endif

endmodule

### sv/stereo_ping_pong_delay_top.sv
// channel   | role  | payload
// ----------+-------+---------------------------------------------
// in_i      | sink  | left_in, right_in (signed SAMPLE_BITS)
// out_o     | src   | left_out, right_out (signed SAMPLE_BITS)
// cfg_*     | write | cfg_idx_i selects register, cfg_data_i value
//
// result passes stage 1, stage 2 and the output register between transfer in and transfer out
// one pair per cycle, unless the output stalls, when the clamped delay is 3 or more; at delay
//   1 or 2 a pair waits for the earlier write to the same ram entry still in the pipeline
// the pace is set by the single read-modify-write on the delay ram
// reset clears control at once; ram entries never written read as zero (fill tracking by
//   write position and a wrap flag), so there is no clearing pass
// two pipeline stages plus the output register absorb output stalls
module stereo_ping_pong_delay_top #(
  parameter int MAX_DELAY   = 262144,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [spp_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [spp_pkg::CFG_W-1:0]  cfg_data_i,
  spp_in_if.sink                     in_i,
  spp_out_if.source                  out_o
);
  import spp_pkg::*;

  localparam int AW = $clog2(MAX_DELAY);
  localparam int CW = ((AW > DLY_W) ? AW : DLY_W) + 1;
  localparam int SB = SAMPLE_BITS;

  logic [DLY_W-1:0]  delay_len_q;
  logic [GAIN_W-1:0] feedback_q, mix_q;
  logic              ping_pong_q;
  logic [AW-1:0]     wp_q;
  logic              wrapped_q;

  logic [CW-1:0]     dly_ext;
  logic [AW-1:0]     d_eff, rp, s1_wp, s2_wp, waddr;
  logic [AW:0]       rd_sum;
  logic [GAIN_W:0]   fb_eff, mix_eff;
  logic              byp_new, hazard, accept, ram_re, ram_we, ok;
  logic [2*SB-1:0]   rdata, wdata;
  issue_t            issue;
  stat_t             st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= DLY_W'(1);
      feedback_q  <= '0;
      mix_q       <= '0;
      ping_pong_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELAY_LEN: delay_len_q <= cfg_data_i[DLY_W-1:0];
        REG_FEEDBACK:  feedback_q  <= cfg_data_i[GAIN_W-1:0];
        REG_MIX:       mix_q       <= cfg_data_i[GAIN_W-1:0];
        REG_PING_PONG: ping_pong_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign fb_eff  = (feedback_q > UNITY[GAIN_W-1:0]) ? UNITY : {1'b0, feedback_q};
  assign mix_eff = (mix_q > UNITY[GAIN_W-1:0]) ? UNITY : {1'b0, mix_q};
  assign byp_new = (mix_q == '0);

  always_comb begin
    dly_ext = CW'(delay_len_q);
    if (dly_ext == '0) d_eff = AW'(1);
    else if (dly_ext > CW'(MAX_DELAY - 1)) d_eff = AW'(MAX_DELAY - 1);
    else d_eff = dly_ext[AW-1:0];
  end

  assign rd_sum = (wp_q >= d_eff) ? ({1'b0, wp_q} - {1'b0, d_eff})
                                  : ({1'b0, wp_q} + (AW+1)'(MAX_DELAY) - {1'b0, d_eff});
  assign rp = rd_sum[AW-1:0];
  assign ok = wrapped_q || (rp < wp_q);

  // a read may not pass a pending write to the same entry
  assign hazard = !byp_new &&
                  ((st.s1_v && !st.s1_byp && (s1_wp == rp)) ||
                   (st.s2_v && !st.s2_byp && (s2_wp == rp)));

  assign in_i.ready = st.s1_free && !hazard;
  assign accept     = in_i.valid && in_i.ready;
  assign ram_re     = accept && !byp_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (ram_re) begin
      if (wp_q == AW'(MAX_DELAY - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
    end
  end

  assign issue.v   = accept;
  assign issue.byp = byp_new;
  assign issue.ok  = ok;

  spp_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_DELAY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (rp),
    .rdata_o (rdata)
  );

  spp_dp #(
    .SB (SB),
    .AW (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .wp_i        (wp_q),
    .left_i      (in_i.left_in),
    .right_i     (in_i.right_in),
    .rdata_i     (rdata),
    .fb_i        (fb_eff),
    .mix_i       (mix_eff),
    .pp_i        (ping_pong_q),
    .out_ready_i (out_o.ready),
    .stat_o      (st),
    .s1_wp_o     (s1_wp),
    .s2_wp_o     (s2_wp),
    .we_o        (ram_we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .out_valid_o (out_o.valid),
    .left_o      (out_o.left_out),
    .right_o     (out_o.right_out)
  );

`ifndef SYNTHESIS
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (waddr != rp))
    else $error("read and write of one entry in the same cycle");
  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> ((wp_q == $past(wp_q) + AW'(1)) || (wp_q == '0)))
    else $error("write position did not step");
  a_bypass_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && byp_new) |=> ($stable(wp_q) && $stable(wrapped_q)))
    else $error("bypass moved the write position");
  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("wrap flag cleared");
`endif

endmodule
